FILE: hw/rtl/sorted_key_binding_table_top_macros.svh
// Assertion macros shared by the table modules
`ifndef SORTED_KEY_BINDING_TABLE_TOP_MACROS_SVH
`define SORTED_KEY_BINDING_TABLE_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset
`define SKB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset
`define SKB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/skbt_pkg.sv
`timescale 1ns / 1ps
package skbt_pkg;

   localparam int TableDepth = 256;
   localparam int KeyW = 16;
   localparam int IdxW = 16;
   localparam int ArgW = 32;
   localparam int EntryW = KeyW + IdxW + ArgW;
   localparam int CsrIdxW = 2;

   typedef enum logic [1:0] {
      REQ_LOOKUP = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_DELETE = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_FALLBACK = 2'd0,
      CSR_ALT_MASK = 2'd1,
      CSR_PFX_MASK = 2'd2,
      CSR_PFX1     = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH_RD,
      S_SEARCH_CMP,
      S_HIT_RD,
      S_HIT_WAIT,
      S_INS_RD,
      S_INS_CMP,
      S_DEL_RD,
      S_DEL_CMP,
      S_DEL_MOVE_RD,
      S_DEL_MOVE_WR,
      S_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic search_init;
      logic search_retry;
      logic search_step;
      logic rd_pos;
      logic rd_prev;
      logic rd_next;
      logic ins_shift;
      logic ins_write;
      logic del_write;
      logic dec_pos;
      logic inc_pos;
      logic cnt_inc;
      logic cnt_dec;
      logic set_hit;
      logic set_full;
      logic set_ok;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic search_active;
      logic search_hit;
      logic retry_ok;
      logic full;
      logic ins_at_front;
      logic ins_move;
      logic del_end;
      logic del_match;
      logic move_end;
   } sts_type;

endpackage

FILE: hw/rtl/skbt_ram.sv
`timescale 1ns / 1ps
module skbt_ram #(
   parameter int Width = 64,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hw/rtl/skbt_datapath.sv
`timescale 1ns / 1ps
`include "sorted_key_binding_table_top_macros.svh"
module skbt_datapath #(
   parameter int TableDepth = skbt_pkg::TableDepth
) (
   input  logic                      clock,
   input  logic                      reset,
   input  skbt_pkg::cmd_type         cmd,
   output skbt_pkg::sts_type         sts,
   input  logic [skbt_pkg::KeyW-1:0] req_key_code,
   input  logic [skbt_pkg::IdxW-1:0] req_func_index,
   input  logic [skbt_pkg::ArgW-1:0] req_bind_arg,
   input  logic                      cfg_fallback,
   input  logic [skbt_pkg::KeyW-1:0] cfg_alt_mask,
   input  logic [skbt_pkg::KeyW-1:0] cfg_pfx_mask,
   input  logic [skbt_pkg::KeyW-1:0] cfg_pfx1,
   output logic [1:0]                rsp_status,
   output logic [skbt_pkg::IdxW-1:0] rsp_found_index,
   output logic [skbt_pkg::ArgW-1:0] rsp_found_arg
);
   localparam int AW = $clog2(TableDepth);
   localparam int CW = AW + 1;
   localparam int KW = skbt_pkg::KeyW;
   localparam int EW = skbt_pkg::EntryW;
   localparam logic [CW-1:0] FullCount = CW'(TableDepth - 1);

   logic [KW-1:0] code_ff, code_in;
   logic [skbt_pkg::IdxW-1:0] fidx_ff;
   logic [skbt_pkg::ArgW-1:0] arg_ff;
   logic [CW-1:0] count_ff, count_in;
   logic signed [CW:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] mid;
   logic [1:0] status_ff;
   logic [skbt_pkg::IdxW-1:0] oidx_ff;
   logic [skbt_pkg::ArgW-1:0] oarg_ff;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;
   logic [KW-1:0] rd_code;
   logic signed [CW:0] sum;

   assign sum = lo_ff + hi_ff;
   assign mid = sum[CW:1];
   assign rd_code = rd_data[EW-1 -: KW];

   always_comb begin
      rd_addr = mid[AW-1:0];
      if (cmd.rd_pos) begin
         rd_addr = pos_ff[AW-1:0];
      end else if (cmd.rd_prev) begin
         rd_addr = AW'(pos_ff - CW'(1));
      end else if (cmd.rd_next) begin
         rd_addr = AW'(pos_ff + CW'(1));
      end
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = pos_ff[AW-1:0];
      wr_data = rd_data;
      if (cmd.ins_shift) begin
         wr_en = 1'b1;
      end else if (cmd.ins_write) begin
         wr_en = 1'b1;
         wr_data = {code_ff, fidx_ff, arg_ff};
      end else if (cmd.del_write) begin
         wr_en = 1'b1;
      end
   end

   skbt_ram #(.Width(EW), .Depth(TableDepth)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      code_in = code_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      pos_in = pos_ff;
      count_in = count_ff;
      if (cmd.load_req) begin
         code_in = req_key_code;
      end
      if (cmd.search_retry) begin
         code_in = (code_ff & ~cfg_alt_mask) | cfg_pfx1;
      end
      if (cmd.search_init || cmd.search_retry) begin
         lo_in = '0;
         hi_in = $signed({1'b0, count_ff}) - (CW+1)'(1);
      end
      if (cmd.search_step) begin
         if (code_ff < rd_code) begin
            hi_in = $signed({1'b0, mid}) - (CW+1)'(1);
         end else begin
            lo_in = $signed({1'b0, mid}) + (CW+1)'(1);
         end
      end
      // insert walks down from the end, the others start at the front
      if (cmd.load_req) begin
         pos_in = cmd.search_init ? '0 : count_ff;
      end
      if (cmd.dec_pos) begin
         pos_in = pos_ff - CW'(1);
      end
      if (cmd.inc_pos) begin
         pos_in = pos_ff + CW'(1);
      end
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         status_ff <= skbt_pkg::ST_NOTFOUND;
      end else begin
         count_ff <= count_in;
         if (cmd.load_req) begin
            status_ff <= skbt_pkg::ST_NOTFOUND;
         end else if (cmd.set_hit || cmd.set_ok) begin
            status_ff <= skbt_pkg::ST_OK;
         end else if (cmd.set_full) begin
            status_ff <= skbt_pkg::ST_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      pos_ff <= pos_in;
      if (cmd.load_req) begin
         fidx_ff <= req_func_index;
         arg_ff <= req_bind_arg;
         oidx_ff <= '0;
         oarg_ff <= '0;
      end else if (cmd.set_hit) begin
         oidx_ff <= rd_data[skbt_pkg::ArgW +: skbt_pkg::IdxW];
         oarg_ff <= rd_data[skbt_pkg::ArgW-1:0];
      end
   end

   assign sts.search_active = (lo_ff <= hi_ff);
   assign sts.search_hit = (rd_code == code_ff);
   assign sts.retry_ok = ((code_ff & cfg_alt_mask) != '0) && cfg_fallback
                         && ((code_ff & cfg_pfx_mask) == '0);
   assign sts.full = (count_ff >= FullCount);
   assign sts.ins_at_front = (pos_ff == '0);
   assign sts.ins_move = (rd_code > code_ff);
   assign sts.del_end = (pos_ff >= count_ff);
   assign sts.del_match = (rd_code == code_ff);
   assign sts.move_end = ((pos_ff + CW'(1)) >= count_ff);

   assign rsp_status = status_ff;
   assign rsp_found_index = oidx_ff;
   assign rsp_found_arg = oarg_ff;

   `SKB_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= FullCount)
   `SKB_ASSERT_NEXT(a_ins_grows, clock, reset, cmd.cnt_inc, count_ff != '0)
   `SKB_ASSERT_IMP(a_no_double_cnt, clock, reset, cmd.cnt_inc, !cmd.cnt_dec)
endmodule

FILE: hw/rtl/skbt_ctrl.sv
`timescale 1ns / 1ps
`include "sorted_key_binding_table_top_macros.svh"
module skbt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_type,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output skbt_pkg::cmd_type   cmd,
   input  skbt_pkg::sts_type   sts
);
   skbt_pkg::state_type state_ff, state_in;
   logic [1:0] kind_ff;
   logic retried_ff, retried_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skbt_pkg::S_IDLE;
         retried_ff <= 1'b0;
         kind_ff <= skbt_pkg::REQ_NONE;
      end else begin
         state_ff <= state_in;
         retried_ff <= retried_in;
         if (req_valid && req_ready) begin
            kind_ff <= req_type;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      retried_in = retried_ff;
      unique case (state_ff)
         skbt_pkg::S_IDLE: begin
            retried_in = 1'b0;
            if (req_valid) begin
               unique case (req_type)
                  skbt_pkg::REQ_LOOKUP: state_in = skbt_pkg::S_SEARCH_RD;
                  skbt_pkg::REQ_INSERT: state_in = skbt_pkg::S_INS_RD;
                  skbt_pkg::REQ_DELETE: state_in = skbt_pkg::S_DEL_RD;
                  default:              state_in = skbt_pkg::S_RESP;
               endcase
            end
         end
         skbt_pkg::S_SEARCH_RD: begin
            if (sts.search_active) begin
               state_in = skbt_pkg::S_SEARCH_CMP;
            end else if (!retried_ff && sts.retry_ok) begin
               retried_in = 1'b1;
            end else begin
               state_in = skbt_pkg::S_RESP;
            end
         end
         skbt_pkg::S_SEARCH_CMP: begin
            if (sts.search_hit) begin
               state_in = skbt_pkg::S_RESP;
            end else begin
               state_in = skbt_pkg::S_SEARCH_RD;
            end
         end
         skbt_pkg::S_INS_RD: begin
            if (sts.full) begin
               state_in = skbt_pkg::S_RESP;
            end else if (sts.ins_at_front) begin
               state_in = skbt_pkg::S_HIT_WAIT;
            end else begin
               state_in = skbt_pkg::S_INS_CMP;
            end
         end
         skbt_pkg::S_INS_CMP: begin
            if (sts.ins_move) begin
               state_in = skbt_pkg::S_INS_RD;
            end else begin
               state_in = skbt_pkg::S_HIT_WAIT;
            end
         end
         skbt_pkg::S_HIT_WAIT: state_in = skbt_pkg::S_RESP;
         skbt_pkg::S_DEL_RD: begin
            if (sts.del_end) begin
               state_in = skbt_pkg::S_RESP;
            end else begin
               state_in = skbt_pkg::S_DEL_CMP;
            end
         end
         skbt_pkg::S_DEL_CMP: begin
            if (sts.del_match) begin
               state_in = skbt_pkg::S_DEL_MOVE_RD;
            end else begin
               state_in = skbt_pkg::S_DEL_RD;
            end
         end
         skbt_pkg::S_DEL_MOVE_RD: begin
            if (sts.move_end) begin
               state_in = skbt_pkg::S_RESP;
            end else begin
               state_in = skbt_pkg::S_DEL_MOVE_WR;
            end
         end
         skbt_pkg::S_DEL_MOVE_WR: state_in = skbt_pkg::S_DEL_MOVE_RD;
         skbt_pkg::S_HIT_RD: state_in = skbt_pkg::S_RESP;
         skbt_pkg::S_RESP: begin
            if (rsp_ready) begin
               state_in = skbt_pkg::S_IDLE;
            end
         end
         default: state_in = skbt_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         skbt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.search_init = (req_type != skbt_pkg::REQ_INSERT);
            end
         end
         skbt_pkg::S_SEARCH_RD: begin
            if (!sts.search_active && !retried_ff && sts.retry_ok) begin
               cmd.search_retry = 1'b1;
            end
         end
         skbt_pkg::S_SEARCH_CMP: begin
            if (sts.search_hit) begin
               cmd.set_hit = 1'b1;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         skbt_pkg::S_INS_RD: begin
            cmd.rd_prev = 1'b1;
            if (sts.full) begin
               cmd.set_full = 1'b1;
            end else if (sts.ins_at_front) begin
               cmd.ins_write = 1'b1;
               cmd.cnt_inc = 1'b1;
               cmd.set_ok = 1'b1;
            end
         end
         skbt_pkg::S_INS_CMP: begin
            if (sts.ins_move) begin
               cmd.ins_shift = 1'b1;
               cmd.dec_pos = 1'b1;
            end else begin
               cmd.ins_write = 1'b1;
               cmd.cnt_inc = 1'b1;
               cmd.set_ok = 1'b1;
            end
         end
         skbt_pkg::S_DEL_RD: cmd.rd_pos = 1'b1;
         skbt_pkg::S_DEL_CMP: begin
            if (!sts.del_match) begin
               cmd.inc_pos = 1'b1;
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         skbt_pkg::S_DEL_MOVE_RD: begin
            cmd.rd_next = 1'b1;
            if (sts.move_end) begin
               cmd.cnt_dec = 1'b1;
               cmd.set_ok = 1'b1;
            end
         end
         skbt_pkg::S_DEL_MOVE_WR: begin
            cmd.del_write = 1'b1;
            cmd.inc_pos = 1'b1;
         end
         skbt_pkg::S_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   `SKB_ASSERT_IMP(a_one_side, clock, reset, 1'b1, !(req_ready && rsp_valid))
   `SKB_ASSERT_IMP(a_wr_excl, clock, reset, cmd.ins_write, !cmd.ins_shift && !cmd.del_write)
   `SKB_ASSERT_NEXT(a_retry_once, clock, reset, cmd.search_retry, retried_ff)
   `SKB_ASSERT_IMP(a_kind_hold, clock, reset,
      state_ff == skbt_pkg::S_INS_CMP, kind_ff == skbt_pkg::REQ_INSERT)
endmodule

FILE: hw/rtl/sorted_key_binding_table_top.sv
// Lookup: binary search, with at most one retry on a rewritten code; insert shifts larger entries up.
// Delete: scans from the front for the code, then moves each later entry down to close the gap.
// Throughput: one request at a time; the next is taken after the response transfer.
// Reset (synchronous, active high) empties the table and clears the configuration registers.
// Table contents are not cleared; the entry count bounds every read whose data is used.
`timescale 1ns / 1ps
module sorted_key_binding_table_top #(
   parameter int TableDepth = skbt_pkg::TableDepth
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_req_type,
   input  logic [skbt_pkg::KeyW-1:0] req_key_code,
   input  logic [skbt_pkg::IdxW-1:0] req_func_index,
   input  logic [skbt_pkg::ArgW-1:0] req_bind_arg,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [skbt_pkg::IdxW-1:0] rsp_found_index,
   output logic [skbt_pkg::ArgW-1:0] rsp_found_arg,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [skbt_pkg::CsrIdxW-1:0] csr_index,
   input  logic [skbt_pkg::KeyW-1:0] csr_data
);
   skbt_pkg::cmd_type cmd;
   skbt_pkg::sts_type sts;
   logic fallback_ff;
   logic [skbt_pkg::KeyW-1:0] alt_mask_ff, pfx_mask_ff, pfx1_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fallback_ff <= 1'b0;
         alt_mask_ff <= '0;
         pfx_mask_ff <= '0;
         pfx1_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            skbt_pkg::CSR_FALLBACK: fallback_ff <= csr_data[0];
            skbt_pkg::CSR_ALT_MASK: alt_mask_ff <= csr_data;
            skbt_pkg::CSR_PFX_MASK: pfx_mask_ff <= csr_data;
            skbt_pkg::CSR_PFX1:     pfx1_ff <= csr_data;
            default: ;
         endcase
      end
   end

   skbt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type (req_req_type),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (cmd),
      .sts      (sts)
   );

   skbt_datapath #(.TableDepth(TableDepth)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_key_code   (req_key_code),
      .req_func_index (req_func_index),
      .req_bind_arg   (req_bind_arg),
      .cfg_fallback   (fallback_ff),
      .cfg_alt_mask   (alt_mask_ff),
      .cfg_pfx_mask   (pfx_mask_ff),
      .cfg_pfx1       (pfx1_ff),
      .rsp_status     (rsp_status),
      .rsp_found_index(rsp_found_index),
      .rsp_found_arg  (rsp_found_arg)
   );
endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import skbt_pkg::*;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] code;
      logic [15:0] fidx;
      logic [31:0] arg;
   } key_req_t;

   typedef struct {
      status_type  st;
      logic [15:0] fidx;
      logic [31:0] arg;
   } key_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_req_type = 2'd0;
   logic [15:0] req_key_code = '0;
   logic [15:0] req_func_index = '0;
   logic [31:0] req_bind_arg = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [15:0] rsp_found_index;
   logic [31:0] rsp_found_arg;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   sorted_key_binding_table_top dut (.*);

   // shadow table and registers
   logic [63:0] bind_tbl [TableDepth];
   int unsigned bind_cnt = 0;
   logic        fb_en = 1'b0;
   logic [15:0] alt_mask = '0, pfx_mask = '0, pfx1 = '0;

   key_req_t pending_reqs[$];
   key_rsp_t expected_rsps[$];
   int send_idle = 0, recv_idle = 0;
   bit hold_armed = 0;
   int hold_cnt = 0;
   int errors = 0, mismatches = 0;
   int n_rsp = 0, n_hit = 0, n_miss = 0, n_full = 0;

   initial forever #4 clock = ~clock;

   function automatic bit find_key(input logic [15:0] code, output int pos);
      int lo, hi, mid;
      lo = 0;
      hi = int'(bind_cnt) - 1;
      pos = 0;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (bind_tbl[mid][63:48] == code) begin
            pos = mid;
            return 1;
         end
         if (code < bind_tbl[mid][63:48]) hi = mid - 1;
         else lo = mid + 1;
      end
      return 0;
   endfunction

   function automatic key_rsp_t apply_key_req(input key_req_t r);
      key_rsp_t o;
      int pos;
      bit hit;
      logic [15:0] code;
      o.st = ST_NOTFOUND;
      o.fidx = '0;
      o.arg = '0;
      code = r.code;
      case (r.kind)
         REQ_LOOKUP: begin
            hit = find_key(code, pos);
            if (!hit && (code & alt_mask) != 0 && fb_en && (code & pfx_mask) == 0) begin
               code = (code & ~alt_mask) | pfx1;
               hit = find_key(code, pos);
            end
            if (hit) begin
               o.st = ST_OK;
               o.fidx = bind_tbl[pos][47:32];
               o.arg = bind_tbl[pos][31:0];
            end
         end
         REQ_INSERT: begin
            if (bind_cnt >= TableDepth - 1) o.st = ST_FULL;
            else begin
               pos = bind_cnt;
               while (pos > 0 && bind_tbl[pos-1][63:48] > code) begin
                  bind_tbl[pos] = bind_tbl[pos-1];
                  pos--;
               end
               bind_tbl[pos] = {code, r.fidx, r.arg};
               bind_cnt++;
               o.st = ST_OK;
            end
         end
         REQ_DELETE: begin
            pos = 0;
            while (pos < bind_cnt && bind_tbl[pos][63:48] != code) pos++;
            if (pos < bind_cnt) begin
               for (int i = pos; i + 1 < bind_cnt; i++) bind_tbl[i] = bind_tbl[i+1];
               bind_cnt--;
               o.st = ST_OK;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // driver
   always @(posedge clock) begin : req_driver
      key_req_t r;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            r.kind = req_req_type;
            r.code = req_key_code;
            r.fidx = req_func_index;
            r.arg = req_bind_arg;
            expected_rsps.push_back(apply_key_req(r));
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
               r = pending_reqs.pop_front();
               req_req_type <= r.kind;
               req_key_code <= r.code;
               req_func_index <= r.fidx;
               req_bind_arg <= r.arg;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : rsp_monitor
      key_rsp_t e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_rsp++;
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("unexpected transfer on response channel");
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_status == ST_OK && e.st == ST_OK) n_hit++;
               if (e.st == ST_NOTFOUND) n_miss++;
               if (e.st == ST_FULL) n_full++;
               if (rsp_status !== e.st || rsp_found_index !== e.fidx ||
                   rsp_found_arg !== e.arg) begin
                  errors++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp st=%0d idx=%h arg=%h got st=%0d idx=%h arg=%h",
                              e.st, e.fidx, e.arg, rsp_status, rsp_found_index,
                              rsp_found_arg);
               end
            end
         end
         if (hold_armed && hold_cnt < 400) begin
            hold_cnt <= hold_cnt + 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   task automatic push_req(input logic [1:0] k, input logic [15:0] c);
      key_req_t r;
      r.kind = k;
      r.code = c;
      r.fidx = 16'($urandom);
      r.arg = $urandom;
      pending_reqs.push_back(r);
   endtask

   function automatic logic [15:0] pick_code();
      logic [15:0] c;
      int v;
      if ($urandom_range(99) < 25) return 16'($urandom);
      c = 16'h0100 + 16'($urandom_range(0, 23)) * 16'h0011;
      v = $urandom_range(2);
      if (v == 1) c = c | 16'h2000;
      if (v == 2) c = c | 16'h8000;
      return c;
   endfunction

   task automatic add_random(input int n, input int ins_pct, input int del_pct);
      int p;
      repeat (n) begin
         p = $urandom_range(99);
         if (p < 3) push_req(REQ_NONE, pick_code());
         else if (p < 3 + ins_pct) push_req(REQ_INSERT, pick_code());
         else if (p < 3 + ins_pct + del_pct) push_req(REQ_DELETE, pick_code());
         else push_req(REQ_LOOKUP, pick_code());
      end
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_valid)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FALLBACK: fb_en = val[0];
         CSR_ALT_MASK: alt_mask = val;
         CSR_PFX_MASK: pfx_mask = val;
         default: pfx1 = val;
      endcase
   endtask

   task automatic set_regs(input logic en, input logic [15:0] am, input logic [15:0] pm,
                           input logic [15:0] p1);
      wait_drained();
      csr_write(CSR_FALLBACK, {15'd0, en});
      csr_write(CSR_ALT_MASK, am);
      csr_write(CSR_PFX_MASK, pm);
      csr_write(CSR_PFX1, p1);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, unused request, extremes, equal codes
      send_idle = 32;
      recv_idle = 81;
      push_req(REQ_LOOKUP, 16'h8041);
      push_req(REQ_DELETE, 16'h0041);
      push_req(REQ_NONE, 16'hFFFF);
      push_req(REQ_INSERT, 16'hFFFF);
      push_req(REQ_INSERT, 16'h0000);
      push_req(REQ_INSERT, 16'h0041);
      push_req(REQ_INSERT, 16'h0041);
      push_req(REQ_INSERT, 16'h0041);
      push_req(REQ_INSERT, 16'h2041);
      push_req(REQ_LOOKUP, 16'h0041);
      push_req(REQ_LOOKUP, 16'h0000);
      push_req(REQ_LOOKUP, 16'hFFFF);
      push_req(REQ_LOOKUP, 16'h8041);
      push_req(REQ_DELETE, 16'h0041);
      push_req(REQ_LOOKUP, 16'h0041);
      push_req(REQ_DELETE, 16'h1234);
      push_req(REQ_LOOKUP, 16'h5555);
      push_req(REQ_LOOKUP, 16'hAAAA);

      set_regs(1'b1, 16'h8000, 16'h6000, 16'h2000);
      push_req(REQ_LOOKUP, 16'h8041);
      push_req(REQ_LOOKUP, 16'hA041);
      add_random(100, 40, 15);

      // long receiver stall while requests keep coming
      set_regs(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF);
      send_idle = 81;
      recv_idle = 32;
      hold_armed = 1;
      add_random(60, 40, 15);
      wait_drained();
      send_idle = 81;

      // fill to capacity, then overflow
      set_regs(1'b0, 16'h0000, 16'hFFFF, 16'h0000);
      send_idle = 0;
      recv_idle = 0;
      repeat (270) push_req(REQ_INSERT, pick_code());
      add_random(60, 5, 10);

      set_regs(1'b1, 16'h8000, 16'h6000, 16'h2000);
      add_random(100, 15, 55);

      wait_drained();
      repeat (50) @(posedge clock);
      if (expected_rsps.size() != 0) errors++;
      $display("%0d responses checked: %0d found or done, %0d not found, %0d full",
               n_rsp, n_hit, n_miss, n_full);
      $display("register settings and receiver stalls exercised, %0d mismatches", mismatches);
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end
endmodule
